@@ src/dltq_pkg.sv @@
// Shared types, widths and codes of the delta-list timer queue.
package dltq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int DELTA_W      = 18;
	localparam int TAG_W        = 8;
	localparam int WORD_W       = DELTA_W + TAG_W;
	localparam int OP_W         = DELTA_W + 1;
	localparam int INTERVAL_W   = 16;
	localparam int DELAY_W      = 16;
	localparam int REMOVED_W    = 5;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

	// input kinds
	localparam logic [1:0] K_ADD    = 2'd0;
	localparam logic [1:0] K_REMOVE = 2'd1;
	localparam logic [1:0] K_TICK   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic                 fired;
		logic [TAG_W-1:0]     id;
		logic [1:0]           status;
		logic [REMOVED_W-1:0] removed;
		logic                 last;
	} res_t;

	function automatic res_t mk_res(input logic fired, input logic [TAG_W-1:0] id,
		input logic [1:0] status, input logic [REMOVED_W-1:0] removed, input logic last);
		res_t r;
		r.fired   = fired;
		r.id      = id;
		r.status  = status;
		r.removed = removed;
		r.last    = last;
		return r;
	endfunction

endpackage

@@ src/dltq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/dltq_alu.sv @@
// Shared add/subtract unit; the top bit of res is carry on add, borrow on subtract.
module dltq_alu #(
	parameter int W = 19
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W:0]   res
);

	always_comb begin
		if (sub) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

@@ src/delta_list_timer_queue_core.sv @@
// Top level of the delta-list timer queue: sequencer, entry RAM, shared ALU and ports.
//
//  channel   direction  transfer condition                  payload
//  s_*       in         s_tvalid & s_tready                 tuser kind, tdata delay/request_id
//  m_*       out        m_tvalid & m_tready                 tdata fired..removed_count, tlast
//  APB       in/out     psel & penable & pwrite & pready    tick_interval at byte address 0
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Add walks the entries until its delay falls short, then shifts the later ones up and inserts.
// Remove visits every stored entry and tick up to every one; the single RAM read port
// with its registered read sets the read-then-evaluate step, and the steps share the one ALU.
// A tick stages a result for each fired id.
// Each result waits in a staging register until the output register is free.
// Reset clears the entry count, elapsed count and interval (100); entries need no clearing.
module delta_list_timer_queue_core #(
	parameter int QUEUE_DEPTH = dltq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// stream in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dltq_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] delay, [23:16] request_id
	input  logic [1:0]                       s_tuser,   // [1:0] kind
	// stream out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dltq_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] fired, [8:1] expired_id,
	                                                    // [10:9] status, [15:11] removed_count
	output logic                             m_tlast,   // last
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dltq_pkg::APB_AW-1:0]      paddr,
	input  logic [dltq_pkg::APB_DW-1:0]      pwdata,
	output logic [dltq_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	import dltq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_TSUM = 9'b000000010,
		S_RD   = 9'b000000100,
		S_EVAL = 9'b000001000,
		S_ADJ  = 9'b000010000,
		S_SHRD = 9'b000100000,
		S_SHWR = 9'b001000000,
		S_INS  = 9'b010000000,
		S_RES  = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [1:0]            op_q;
	logic [TAG_W-1:0]      rid_q;
	logic [DELTA_W-1:0]    acc_q;       // remaining delay, carried delta or elapsed, by op
	logic [DELTA_W-1:0]    elapsed_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_q;
	logic [CNT_W-1:0]      wr_q;
	logic [WORD_W-1:0]     hold_q;
	logic                  copy_q;
	logic                  pend_valid_q;
	logic [TAG_W-1:0]      pend_tag_q;
	res_t                  res_q;
	res_t                  out_q;
	logic                  m_tvalid_q;

	logic [CNT_W-1:0]      rd_nxt;
	logic [CNT_W-1:0]      sh_src;
	logic                  out_free;

	logic [OP_W-1:0]       alu_a;
	logic [OP_W-1:0]       alu_b;
	logic                  alu_sub;
	logic [OP_W:0]         alu_res;
	logic                  alu_borrow;
	logic [DELTA_W-1:0]    alu_low;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [WORD_W-1:0]     ram_rdata;

	logic [DELTA_W-1:0]    rd_delta;
	logic [TAG_W-1:0]      rd_tag;
	logic [DELTA_W-1:0]    hold_delta;
	logic [TAG_W-1:0]      hold_tag;

	assign rd_delta   = ram_rdata[WORD_W-1:TAG_W];
	assign rd_tag     = ram_rdata[TAG_W-1:0];
	assign hold_delta = hold_q[WORD_W-1:TAG_W];
	assign hold_tag   = hold_q[TAG_W-1:0];
	assign rd_nxt     = rd_q + 1'b1;
	assign sh_src     = wr_q - 1'b1;
	assign out_free   = !m_tvalid_q || m_tready;

	// Ports
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.removed, out_q.status, out_q.id, out_q.fired};
	assign m_tlast  = out_q.last;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? {{(APB_DW-INTERVAL_W){1'b0}}, interval_q} : '0;

	// Operand select for the shared unit
	always_comb begin
		alu_a   = {1'b0, acc_q};
		alu_b   = {1'b0, rd_delta};
		alu_sub = (op_q != K_REMOVE);
		if (state_q == S_TSUM) begin
			// elapsed plus interval, saturated below
			alu_a   = {1'b0, elapsed_q};
			alu_b   = OP_W'(interval_q);
			alu_sub = 1'b0;
		end else if (state_q == S_ADJ) begin
			// stopped entry's delta minus remaining delay or overshoot
			alu_a   = {1'b0, hold_delta};
			alu_b   = {1'b0, acc_q};
			alu_sub = 1'b1;
		end
	end

	dltq_alu #(.W(OP_W)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	assign alu_borrow = alu_res[OP_W];
	assign alu_low    = alu_res[DELTA_W-1:0];

	// Entry RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = rd_q[IDX_W-1:0];
		unique case (state_q)
			S_RD: begin
				if (rd_q == cnt_q) begin
					if (op_q == K_ADD) begin
						// walked past the tail: append
						ram_we    = 1'b1;
						ram_waddr = cnt_q[IDX_W-1:0];
						ram_wdata = {acc_q, rid_q};
					end
				end else begin
					ram_re = 1'b1;
				end
			end
			S_EVAL: begin
				if (op_q == K_REMOVE && rd_tag != rid_q) begin
					// keep entry, fold in deltas of removed predecessors
					ram_we    = 1'b1;
					ram_wdata = {alu_low, rd_tag};
				end else if (op_q == K_TICK && copy_q) begin
					ram_we = 1'b1;
				end
			end
			S_ADJ: begin
				if (op_q == K_TICK) begin
					// new head takes the overshoot off its delta
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = {alu_low, hold_tag};
				end
			end
			S_SHRD: begin
				if (wr_q == rd_nxt) begin
					ram_we    = 1'b1;
					ram_wdata = hold_q;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = sh_src[IDX_W-1:0];
				end
			end
			S_SHWR: begin
				ram_we = 1'b1;
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = rd_q[IDX_W-1:0];
				ram_wdata = {acc_q, rid_q};
			end
			default: begin
			end
		endcase
	end

	dltq_ram #(.WIDTH(WORD_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			elapsed_q    <= '0;
			interval_q   <= INTERVAL_RESET;
			m_tvalid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				interval_q <= pwdata[INTERVAL_W-1:0];
			end
			// drop valid once taken, unless a staged result refills it below
			if (m_tvalid_q && m_tready && state_q != S_RES) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q         <= s_tuser;
						rid_q        <= s_tdata[IN_DATA_W-1:DELAY_W];
						acc_q        <= (s_tuser == K_REMOVE) ? '0
							: DELTA_W'(s_tdata[DELAY_W-1:0]);
						rd_q         <= '0;
						wr_q         <= '0;
						copy_q       <= 1'b0;
						pend_valid_q <= 1'b0;
						case (s_tuser)
							K_ADD: begin
								if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
									// drop: list full
									res_q   <= mk_res(1'b0, '0, ST_FULL, '0, 1'b1);
									state_q <= S_RES;
								end else begin
									if (cnt_q == '0) begin
										elapsed_q <= '0;
									end
									state_q <= S_RD;
								end
							end
							K_REMOVE: begin
								state_q <= S_RD;
							end
							K_TICK: begin
								if (cnt_q == '0) begin
									res_q   <= mk_res(1'b0, '0, ST_NONE, '0, 1'b1);
									state_q <= S_RES;
								end else begin
									state_q <= S_TSUM;
								end
							end
							default: begin
								res_q   <= mk_res(1'b0, '0, ST_NONE, '0, 1'b1);
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_TSUM: begin
					acc_q   <= alu_res[DELTA_W] ? '1 : alu_low;
					state_q <= S_RD;
				end
				S_RD: begin
					if (rd_q == cnt_q) begin
						case (op_q)
							K_ADD: begin
								cnt_q <= cnt_q + 1'b1;
								res_q <= mk_res(1'b0, '0, ST_DONE, '0, 1'b1);
							end
							K_REMOVE: begin
								cnt_q <= wr_q;
								res_q <= mk_res(1'b0, '0, (cnt_q != wr_q) ? ST_DONE : ST_NONE,
									REMOVED_W'(cnt_q - wr_q), 1'b1);
							end
							default: begin
								// tick ran out of entries or finished the copy
								cnt_q        <= wr_q;
								elapsed_q    <= '0;
								pend_valid_q <= 1'b0;
								res_q        <= mk_res(1'b1, pend_tag_q, ST_DONE, '0, 1'b1);
							end
						endcase
						state_q <= S_RES;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					hold_q <= ram_rdata;
					case (op_q)
						K_ADD: begin
							if (alu_borrow) begin
								state_q <= S_ADJ;
							end else begin
								acc_q   <= alu_low;
								rd_q    <= rd_nxt;
								state_q <= S_RD;
							end
						end
						K_REMOVE: begin
							rd_q <= rd_nxt;
							if (rd_tag == rid_q) begin
								acc_q <= alu_low;
							end else begin
								acc_q <= '0;
								wr_q  <= wr_q + 1'b1;
							end
							state_q <= S_RD;
						end
						default: begin
							if (copy_q) begin
								wr_q    <= wr_q + 1'b1;
								rd_q    <= rd_nxt;
								state_q <= S_RD;
							end else if (!alu_borrow) begin
								// head expires: report the previous one, hold this one
								acc_q        <= alu_low;
								rd_q         <= rd_nxt;
								pend_tag_q   <= rd_tag;
								pend_valid_q <= 1'b1;
								if (pend_valid_q) begin
									res_q   <= mk_res(1'b1, pend_tag_q, ST_DONE, '0, 1'b0);
									state_q <= S_RES;
								end else begin
									state_q <= S_RD;
								end
							end else if (pend_valid_q) begin
								state_q <= S_ADJ;
							end else begin
								elapsed_q <= acc_q;
								res_q     <= mk_res(1'b0, '0, ST_NONE, '0, 1'b1);
								state_q   <= S_RES;
							end
						end
					endcase
				end
				S_ADJ: begin
					if (op_q == K_ADD) begin
						hold_q  <= {alu_low, hold_tag};
						wr_q    <= cnt_q;
						state_q <= S_SHRD;
					end else begin
						wr_q    <= CNT_W'(1);
						rd_q    <= rd_nxt;
						copy_q  <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_SHRD: begin
					state_q <= (wr_q == rd_nxt) ? S_INS : S_SHWR;
				end
				S_SHWR: begin
					wr_q    <= sh_src;
					state_q <= S_SHRD;
				end
				S_INS: begin
					cnt_q   <= cnt_q + 1'b1;
					res_q   <= mk_res(1'b0, '0, ST_DONE, '0, 1'b1);
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_q      <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= res_q.last ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("fired id left pending at idle");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && op_q != K_ADD) |-> (wr_q <= rd_q))
		else $error("compaction write overtook read");

	a_res_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && !out_free) |=> (state_q == S_RES))
		else $error("staged result lost while output busy");

endmodule
